// ===== rtl/core/ecta_pkg.sv =====
// Package with shared types and constants for the exact cycle time accumulator.
package ecta_pkg;

    // Width of the stored time; the largest time is 2^TIME_WIDTH - 1 ns.
    localparam int unsigned TIME_WIDTH = 64;
    // Width of the cycle count, the registers and the phase.
    localparam int unsigned WORD_W     = 64;
    // Number of bit steps of the shift-add multiply and of the restoring divide.
    localparam int unsigned STEPS      = WORD_W;
    localparam int unsigned CNT_W      = $clog2(STEPS);
    localparam int unsigned ADDR_W     = 4;

    localparam logic [WORD_W-1:0] TIME_LIMIT =
        {WORD_W{1'b1}} >> (WORD_W - TIME_WIDTH);

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_CAPACITY = 2'd2;

    // Register indexes.
    localparam logic REG_PHASE_MODULUS = 1'b0;
    localparam logic REG_NS_STEP_NUM   = 1'b1;

    // Configuration values handed from the register block to the core.
    typedef struct packed {
        logic [WORD_W-1:0] phase_modulus;
        logic [WORD_W-1:0] ns_step_numerator;
    } t_cfg;

    // Control of the shared adder: invert operand b and carry in.
    typedef struct packed {
        logic inv;
        logic cin;
    } t_alu_op;

endpackage

// ===== rtl/core/ecta_alu.sv =====
// Shared 65-bit adder and subtractor used by every step of the sequencer.
module ecta_alu (
    input  logic [ecta_pkg::WORD_W:0]   i_a,
    input  logic [ecta_pkg::WORD_W:0]   i_b,
    input  ecta_pkg::t_alu_op           i_op,
    output logic [ecta_pkg::WORD_W+1:0] o_sum
);
    import ecta_pkg::*;

    logic [WORD_W:0] w_b;

    // With inv and cin set, o_sum is a - b and the top bit is the no-borrow flag.
    assign w_b   = i_op.inv ? ~i_b : i_b;
    assign o_sum = {1'b0, i_a} + {1'b0, w_b} + {{(WORD_W+1){1'b0}}, i_op.cin};

endmodule

// ===== rtl/core/ecta_cfg.sv =====
// APB-style configuration registers of the exact cycle time accumulator.
module ecta_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ecta_pkg::ADDR_W-1:0] paddr,
    input  logic [ecta_pkg::WORD_W-1:0] pwdata,
    output logic [ecta_pkg::WORD_W-1:0] prdata,
    output logic                        pready,
    output ecta_pkg::t_cfg              o_cfg
);
    import ecta_pkg::*;

    logic [WORD_W-1:0] r_phase_modulus;
    logic [WORD_W-1:0] r_ns_step_numerator;
    logic              w_wr;
    logic              w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    // Registers sit at byte addresses 0 and 8.
    assign w_idx  = paddr[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_modulus     <= WORD_W'(1);
            r_ns_step_numerator <= WORD_W'(1);
        end else if (w_wr) begin
            case (w_idx)
                REG_PHASE_MODULUS: r_phase_modulus     <= pwdata;
                REG_NS_STEP_NUM:   r_ns_step_numerator <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_PHASE_MODULUS: prdata = r_phase_modulus;
            REG_NS_STEP_NUM:   prdata = r_ns_step_numerator;
            default:           prdata = '0;
        endcase
    end

    assign o_cfg.phase_modulus     = r_phase_modulus;
    assign o_cfg.ns_step_numerator = r_ns_step_numerator;

endmodule

// ===== rtl/core/exact_cycle_time_accumulator.sv =====
// Top level of the exact cycle time accumulator: sequencer, state and result register.
//
// The block keeps an exact time as whole nanoseconds plus a phase counted in
// units of 1/phase_modulus ns. Each item carries a cycle count; the block forms
// the 128-bit product of the count and ns_step_numerator, divides it by
// phase_modulus, adds the remainder to the phase (carrying one nanosecond on
// wrap) and adds the quotient and carry to the time. All arithmetic runs on a
// single shared 65-bit adder: 64 shift-add multiply steps, one range check, 64
// restoring divide steps, up to three phase steps and one time step. The block
// takes no new item until the current one has moved into the output register,
// so the next item can be accepted in the same cycle that the result appears;
// the output register may still hold an earlier result while the next item is
// being worked on, and a stalled output register holds the finished item back
// until it is free.
// Status 1 flags a zero register or a phase not below the modulus, status 2 a
// quotient or time beyond the time capacity; on either the state is unchanged
// and the result carries the unchanged time and phase. Configuration must only
// be written while the block is idle.
module exact_cycle_time_accumulator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration port.
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ecta_pkg::ADDR_W-1:0] paddr,
    input  logic [ecta_pkg::WORD_W-1:0] pwdata,
    output logic [ecta_pkg::WORD_W-1:0] prdata,
    output logic                        pready,
    // Input item channel.
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [ecta_pkg::WORD_W-1:0] i_cycle_count,
    // Result item channel.
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [1:0]                  o_status,
    output logic [ecta_pkg::WORD_W-1:0] o_time_ns,
    output logic [ecta_pkg::WORD_W-1:0] o_time_phase
);
    import ecta_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_MUL   = 9'b000000010,
        S_CHKHI = 9'b000000100,
        S_DIV   = 9'b000001000,
        S_PHD   = 9'b000010000,
        S_PHC   = 9'b000100000,
        S_PHA   = 9'b001000000,
        S_TIME  = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_cfg              w_cfg;
    t_alu_op           w_op;
    logic [WORD_W:0]   w_a;
    logic [WORD_W:0]   w_b;
    logic [WORD_W+1:0] w_sum;
    logic              w_ge;
    logic              w_last;
    logic              w_accept;
    logic              w_invalid;
    logic              w_load_out;
    logic              w_over;

    t_state            r_state,   n_state;
    logic [CNT_W-1:0]  r_cnt,     n_cnt;
    // r_hi holds the product's high word, then the remainder.
    // r_lo holds the multiplier and product's low word, then the quotient.
    logic [WORD_W-1:0] r_hi,      n_hi;
    logic [WORD_W-1:0] r_lo,      n_lo;
    logic [WORD_W-1:0] r_tmp,     n_tmp;
    logic [WORD_W-1:0] r_newph,   n_newph;
    logic              r_carry,   n_carry;
    logic [1:0]        r_status,  n_status;
    logic [WORD_W-1:0] r_elapsed, n_elapsed;
    logic [WORD_W-1:0] r_phase,   n_phase;
    logic              r_out_valid;
    logic [1:0]        r_o_status;
    logic [WORD_W-1:0] r_o_ns;
    logic [WORD_W-1:0] r_o_phase;

    ecta_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    ecta_alu u_alu (
        .i_a   (w_a),
        .i_b   (w_b),
        .i_op  (w_op),
        .o_sum (w_sum)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_invalid  = (w_cfg.phase_modulus == '0) || (w_cfg.ns_step_numerator == '0) ||
                        (r_phase >= w_cfg.phase_modulus);
    assign w_last     = (r_cnt == CNT_W'(STEPS - 1));
    // After a subtraction the top bit of the sum says a >= b.
    assign w_ge       = w_sum[WORD_W+1];
    assign w_load_out = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    // The quotient alone, or the new time, does not fit the time capacity.
    assign w_over     = ((r_lo & ~TIME_LIMIT) != '0) ||
                        (w_sum[WORD_W+1:WORD_W] != 2'b00) ||
                        ((w_sum[WORD_W-1:0] & ~TIME_LIMIT) != '0);

    // Operand selection for the shared adder.
    always_comb begin
        w_a = {1'b0, r_hi};
        w_b = {1'b0, w_cfg.phase_modulus};
        w_op.inv = 1'b1;
        w_op.cin = 1'b1;
        case (r_state)
            S_MUL: begin
                w_b = r_lo[0] ? {1'b0, w_cfg.ns_step_numerator} : '0;
                w_op.inv = 1'b0;
                w_op.cin = 1'b0;
            end
            S_CHKHI: ;
            S_DIV: begin
                w_a = {r_hi, r_lo[WORD_W-1]};
            end
            S_PHD: begin
                w_a = {1'b0, w_cfg.phase_modulus};
                w_b = {1'b0, r_hi};
            end
            S_PHC: begin
                w_a = {1'b0, r_phase};
                w_b = {1'b0, r_tmp};
            end
            S_PHA: begin
                w_a = {1'b0, r_phase};
                w_b = {1'b0, r_hi};
                w_op.inv = 1'b0;
                w_op.cin = 1'b0;
            end
            S_TIME: begin
                w_a = {1'b0, r_elapsed};
                w_b = {1'b0, r_lo};
                w_op.inv = 1'b0;
                w_op.cin = r_carry;
            end
            default: ;
        endcase
    end

    // Sequencer.
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_hi      = r_hi;
        n_lo      = r_lo;
        n_tmp     = r_tmp;
        n_newph   = r_newph;
        n_carry   = r_carry;
        n_status  = r_status;
        n_elapsed = r_elapsed;
        n_phase   = r_phase;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_hi  = '0;
                    n_lo  = i_cycle_count;
                    n_cnt = '0;
                    if (w_invalid) begin
                        n_status = ST_INVALID;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                // Add the multiplicand when the low bit is set, then shift right.
                n_hi  = w_sum[WORD_W:1];
                n_lo  = {w_sum[0], r_lo[WORD_W-1:1]};
                n_cnt = r_cnt + CNT_W'(1);
                if (w_last) begin
                    n_state = S_CHKHI;
                end
            end
            S_CHKHI: begin
                n_cnt = '0;
                if (w_ge) begin
                    n_status = ST_CAPACITY;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                // Shift one dividend bit in, subtract the modulus when it fits.
                n_hi  = w_ge ? w_sum[WORD_W-1:0] : w_a[WORD_W-1:0];
                n_lo  = {r_lo[WORD_W-2:0], w_ge};
                n_cnt = r_cnt + CNT_W'(1);
                if (w_last) begin
                    n_state = S_PHD;
                end
            end
            S_PHD: begin
                n_tmp   = w_sum[WORD_W-1:0];
                n_state = S_PHC;
            end
            S_PHC: begin
                if (w_ge) begin
                    n_newph = w_sum[WORD_W-1:0];
                    n_carry = 1'b1;
                    n_state = S_TIME;
                end else begin
                    n_state = S_PHA;
                end
            end
            S_PHA: begin
                n_newph = w_sum[WORD_W-1:0];
                n_carry = 1'b0;
                n_state = S_TIME;
            end
            S_TIME: begin
                if (w_over) begin
                    n_status = ST_CAPACITY;
                end else begin
                    n_status  = ST_OK;
                    n_elapsed = w_sum[WORD_W-1:0];
                    n_phase   = r_newph;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_carry     <= 1'b0;
            r_status    <= ST_OK;
            r_elapsed   <= '0;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_carry   <= n_carry;
            r_status  <= n_status;
            r_elapsed <= n_elapsed;
            r_phase   <= n_phase;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi    <= n_hi;
        r_lo    <= n_lo;
        r_tmp   <= n_tmp;
        r_newph <= n_newph;
        if (w_load_out) begin
            r_o_status <= r_status;
            r_o_ns     <= r_elapsed;
            r_o_phase  <= r_phase;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_o_status;
    assign o_time_ns    = r_o_ns;
    assign o_time_phase = r_o_phase;

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the exact cycle time accumulator.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ecta_pkg::*;

    // Cycles without any accepted item or register access before the run is
    // declared hung.
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned RANDOM_ITEMS = 1000;
    localparam int unsigned MAX_PRINTS   = 50;

    typedef struct packed {
        logic [1:0]        status;
        logic [WORD_W-1:0] time_ns;
        logic [WORD_W-1:0] time_phase;
    } t_tick;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                psel          = 1'b0;
    logic                penable       = 1'b0;
    logic                pwrite        = 1'b0;
    logic [ADDR_W-1:0]   paddr         = '0;
    logic [WORD_W-1:0]   pwdata        = '0;
    logic [WORD_W-1:0]   prdata;
    logic                pready;
    logic                i_in_valid    = 1'b0;
    logic                o_in_ready;
    logic [WORD_W-1:0]   i_cycle_count = '0;
    logic                o_out_valid;
    logic                i_out_ready   = 1'b0;
    logic [1:0]          o_status;
    logic [WORD_W-1:0]   o_time_ns;
    logic [WORD_W-1:0]   o_time_phase;

    // Shadow of the block: configuration and the accumulated time.
    logic [WORD_W-1:0]   cfg_modulus   = 64'd1;
    logic [WORD_W-1:0]   cfg_step_num  = 64'd1;
    logic [WORD_W-1:0]   acc_ns        = '0;
    logic [WORD_W-1:0]   acc_phase     = '0;

    t_tick               expected_ticks[$];
    int unsigned         mismatch_count = 0;
    int unsigned         idle_cycles    = 0;
    bit                  steady_flow    = 1'b0;

    exact_cycle_time_accumulator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cycle_count (i_cycle_count),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_time_ns     (o_time_ns),
        .o_time_phase  (o_time_phase)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Advances the shadow time by one cycle count and returns the result the
    // block must give. On any error the shadow state is left as it was.
    function automatic t_tick advance_clock(input logic [WORD_W-1:0] cnt);
        logic [2*WORD_W-1:0] product;
        logic [2*WORD_W-1:0] wide;
        logic [WORD_W-1:0]   quo;
        logic [WORD_W-1:0]   rem;
        logic [WORD_W-1:0]   to_wrap;
        logic [WORD_W-1:0]   next_phase;
        logic                carry;
        t_tick               tick;
        tick.status = ST_OK;
        if (cfg_modulus == 0 || cfg_step_num == 0 || acc_phase >= cfg_modulus) begin
            tick.status = ST_INVALID;
        end else begin
            product = {{WORD_W{1'b0}}, cnt} * {{WORD_W{1'b0}}, cfg_step_num};
            if (product[2*WORD_W-1:WORD_W] >= cfg_modulus) begin
                tick.status = ST_CAPACITY;
            end else begin
                wide = product / {{WORD_W{1'b0}}, cfg_modulus};
                quo  = wide[WORD_W-1:0];
                wide = product % {{WORD_W{1'b0}}, cfg_modulus};
                rem  = wide[WORD_W-1:0];
                // The phase wraps once it reaches the modulus.
                to_wrap    = cfg_modulus - rem;
                carry      = (acc_phase >= to_wrap);
                next_phase = carry ? acc_phase - to_wrap : acc_phase + rem;
                if (quo > TIME_LIMIT || (carry && quo == TIME_LIMIT)) begin
                    tick.status = ST_CAPACITY;
                end else begin
                    quo = quo + {{(WORD_W-1){1'b0}}, carry};
                    if (acc_ns > TIME_LIMIT || acc_ns > TIME_LIMIT - quo) begin
                        tick.status = ST_CAPACITY;
                    end else begin
                        acc_ns    = acc_ns + quo;
                        acc_phase = next_phase;
                    end
                end
            end
        end
        tick.time_ns    = acc_ns;
        tick.time_phase = acc_phase;
        return tick;
    endfunction

    // Random word of the given width; optionally with its top bit set.
    function automatic logic [WORD_W-1:0] rand_word(input int unsigned bits, input bit top);
        logic [WORD_W-1:0] v;
        v = {$urandom, $urandom};
        if (bits == 0) begin
            return '0;
        end
        if (bits < WORD_W) begin
            v = v & ((64'd1 << bits) - 64'd1);
        end
        if (top) begin
            v[bits-1] = 1'b1;
        end
        return v;
    endfunction

    // Idle cycles before the next item on either side.
    function automatic int unsigned draw_gap();
        if (steady_flow || $urandom_range(0, 2) == 0) begin
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    task automatic note_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
        if (mismatch_count < MAX_PRINTS) begin
            $display("mismatch at %0t: %s got %h, want %h", $realtime, what, got, want);
        end
        mismatch_count++;
    endtask

    // Offers one cycle count and records the expected result once it is taken.
    // Entered and left at a rising edge; valid stays high if no gap follows.
    task automatic send_count(input logic [WORD_W-1:0] cnt);
        int unsigned gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_cycle_count <= cnt;
        do @(posedge i_clk); while (!o_in_ready);
        expected_ticks.push_back(advance_clock(cnt));
    endtask

    // Stops sending and waits until every expected result has come back.
    task automatic wait_for_idle();
        i_in_valid <= 1'b0;
        while (expected_ticks.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes one register through the configuration port and reads it back.
    task automatic write_register(input logic idx, input logic [WORD_W-1:0] value);
        wait_for_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== value) begin
            note_mismatch("register readback", prdata, value);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_PHASE_MODULUS) begin
            cfg_modulus = value;
        end else begin
            cfg_step_num = value;
        end
    endtask

    // Counts straight from the reset registers: one ns per cycle, no phase.
    task automatic test_reset_state();
        send_count(64'd0);
        send_count(64'd1);
        send_count(64'd5);
    endtask

    // Product high word at the modulus, and a quotient at the limit that the
    // phase carry pushes over.
    task automatic test_quotient_limits();
        write_register(REG_NS_STEP_NUM, 64'd2);
        send_count('1);
        write_register(REG_PHASE_MODULUS, 64'd4);
        write_register(REG_NS_STEP_NUM, 64'd1);
        send_count(64'd1);
        // (2^33 + 1) * (2^33 - 1) / 4 leaves the largest quotient, remainder 3.
        write_register(REG_NS_STEP_NUM, 64'h0000_0001_FFFF_FFFF);
        send_count(64'h0000_0002_0000_0001);
    endtask

    task automatic test_count_extremes();
        write_register(REG_PHASE_MODULUS, 64'd1000);
        write_register(REG_NS_STEP_NUM, 64'd3);
        send_count(64'd0);
        send_count(64'd1);
        send_count('1);
        send_count(64'hAAAA_AAAA_AAAA_AAAA);
        send_count(64'h5555_5555_5555_5555);
    endtask

    // Either register at zero makes every item invalid.
    task automatic test_zero_registers();
        write_register(REG_PHASE_MODULUS, 64'd0);
        send_count(64'd7);
        send_count('1);
        write_register(REG_PHASE_MODULUS, 64'd1000);
        write_register(REG_NS_STEP_NUM, 64'd0);
        send_count(64'd7);
        send_count('1);
    endtask

    // Shrinking the modulus onto the phase blocks the block until a larger modulus
    // is written; the last item then wraps the phase.
    task automatic test_phase_above_modulus();
        write_register(REG_PHASE_MODULUS, 64'd1000);
        write_register(REG_NS_STEP_NUM, 64'd7);
        send_count(64'd100);
        write_register(REG_PHASE_MODULUS, 64'd500);
        send_count(64'd1);
        write_register(REG_PHASE_MODULUS, acc_phase);
        send_count(64'd1);
        write_register(REG_PHASE_MODULUS, acc_phase + 64'd1);
        send_count(64'd1);
    endtask

    // Phases of random configuration, each followed by a run of counts sized
    // so that the time grows slowly and most items do real arithmetic.
    task automatic test_random_phases();
        int unsigned       sent;
        int unsigned       wm;
        int unsigned       wn;
        int                wc_max;
        int unsigned       run_len;
        logic [WORD_W-1:0] mod_val;
        logic [WORD_W-1:0] num_val;
        logic [WORD_W-1:0] cnt;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            wn = ($urandom_range(0, 7) == 0) ? WORD_W : $urandom_range(1, WORD_W);
            wm = ($urandom_range(0, 7) == 0) ? WORD_W : $urandom_range(1, WORD_W);
            if (wn > wm + 40) begin
                wm = wn - 40;
            end
            mod_val = rand_word(wm, 1'b1);
            num_val = rand_word(wn, 1'b1);
            if (wm == WORD_W && $urandom_range(0, 3) == 0) begin
                mod_val = '1;
            end
            if (wn == WORD_W && $urandom_range(0, 3) == 0) begin
                num_val = '1;
            end
            // Mostly keep the modulus above the current phase.
            if (mod_val <= acc_phase && $urandom_range(0, 3) != 0) begin
                mod_val = (acc_phase >= 64'hFFFF_FFFF_FFFF_FF00) ? '1 :
                          acc_phase + 64'd1 + 64'($urandom_range(0, 255));
            end
            run_len = $urandom_range(20, 60);
            if ($urandom_range(0, 15) == 0) begin
                if ($urandom_range(0, 1) == 0) begin
                    mod_val = '0;
                end else begin
                    num_val = '0;
                end
                run_len = 6;
            end
            write_register(REG_PHASE_MODULUS, mod_val);
            write_register(REG_NS_STEP_NUM, num_val);
            steady_flow = ($urandom_range(0, 3) == 0);
            wc_max = 50 - (int'(wn) - int'(wm));
            if (wc_max > int'(WORD_W)) begin
                wc_max = WORD_W;
            end
            if (wc_max < 0) begin
                wc_max = 0;
            end
            repeat (run_len) begin
                if (wn >= wm + 2 && $urandom_range(0, 11) == 0) begin
                    // Top count bit with a step above twice the modulus
                    // always overflows the quotient.
                    cnt = rand_word(WORD_W, 1'b1);
                end else begin
                    cnt = rand_word($urandom_range(0, wc_max), 1'b0);
                end
                send_count(cnt);
                sent++;
            end
        end
        steady_flow = 1'b0;
    endtask

    // With both registers at the maximum each cycle is one ns; fill the time
    // to its limit and then try to pass it.
    task automatic test_time_overflow();
        write_register(REG_PHASE_MODULUS, '1);
        write_register(REG_NS_STEP_NUM, '1);
        send_count(TIME_LIMIT - acc_ns);
        send_count(64'd1);
        send_count(64'd0);
        send_count('1);
    endtask

    // Result side: stall a random number of cycles before taking each item.
    initial begin : result_sink
        int unsigned stall;
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(i_rst_n && o_out_valid));
        end
    end

    // Compares every accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_tick want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_ticks.size() == 0) begin
                note_mismatch("unexpected result, time", o_time_ns, '0);
            end else begin
                want = expected_ticks.pop_front();
                if (o_status !== want.status) begin
                    note_mismatch("status", 64'(o_status), 64'(want.status));
                end
                if (o_time_ns !== want.time_ns) begin
                    note_mismatch("time_ns", o_time_ns, want.time_ns);
                end
                if (o_time_phase !== want.time_phase) begin
                    note_mismatch("time_phase", o_time_phase, want.time_phase);
                end
            end
        end
    end

    // Ends a hung run: nothing accepted on any port for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_quotient_limits();
        test_count_extremes();
        test_zero_registers();
        test_phase_above_modulus();
        test_random_phases();
        test_time_overflow();
        wait_for_idle();
        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
